@@ src/rrtt_pkg.sv @@
// shared types, codes and defaults of the request retry timeout tracker
package rrtt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int MAX_PAYLOAD_DEF = 256;
	localparam logic [31:0] RESET_TIMEOUT = 32'd3000;
	localparam int MAX_RES = 8;
	localparam int QDEPTH = 2;

	// input actions
	localparam logic [1:0] ACT_OPEN = 2'd0;
	localparam logic [1:0] ACT_RESP = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	// command kinds after classification
	localparam logic [2:0] K_OPEN = 3'd0;
	localparam logic [2:0] K_LONG = 3'd1;
	localparam logic [2:0] K_RESP = 3'd2;
	localparam logic [2:0] K_TICK = 3'd3;
	localparam logic [2:0] K_NONE = 3'd4;

	// result events
	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_OPENED    = 4'd1;
	localparam logic [3:0] EV_TOOLONG   = 4'd2;
	localparam logic [3:0] EV_NOSLOT    = 4'd3;
	localparam logic [3:0] EV_SENDFAIL  = 4'd4;
	localparam logic [3:0] EV_DONE      = 4'd5;
	localparam logic [3:0] EV_UNMATCHED = 4'd6;
	localparam logic [3:0] EV_RETRY     = 4'd7;
	localparam logic [3:0] EV_TIMEOUT   = 4'd8;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_time;
		logic [15:0] match_id;
		logic [31:0] request_timeout;
		logic [7:0]  retry_limit_in;
		logic [15:0] payload_length;
		logic        send_ok;
	} req_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [2:0]  slot_index;
		logic [15:0] id_out;
		logic [7:0]  attempt;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now_time;
		logic [15:0] match_id;
		logic [31:0] timeout;
		logic [7:0]  retry_limit;
		logic        send_ok;
	} cmd_t;

endpackage

@@ src/rrtt_chan_if.sv @@
// valid/ready channel carrying one payload per beat
interface rrtt_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/rrtt_front.sv @@
// front end: default timeout register and classification of input beats
module rrtt_front #(
	parameter int MAX_PAYLOAD = rrtt_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrtt_chan_if.sink   req,
	rrtt_chan_if.sink   cfg,
	rrtt_chan_if.source cmd
);

	logic [31:0] default_timeout_q;
	rrtt_pkg::cmd_t c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_timeout_q <= rrtt_pkg::RESET_TIMEOUT;
		end else if (cfg.valid) begin
			default_timeout_q <= cfg.data;
		end
	end

	always_comb begin
		c.now_time    = req.data.now_time;
		c.match_id    = req.data.match_id;
		c.retry_limit = req.data.retry_limit_in;
		c.send_ok     = req.data.send_ok;
		c.timeout     = (req.data.request_timeout != 32'd0) ? req.data.request_timeout
			: default_timeout_q;
		case (req.data.action)
			rrtt_pkg::ACT_OPEN: begin
				c.kind = ({1'b0, req.data.payload_length} > 17'(MAX_PAYLOAD))
					? rrtt_pkg::K_LONG : rrtt_pkg::K_OPEN;
			end
			rrtt_pkg::ACT_RESP: c.kind = rrtt_pkg::K_RESP;
			rrtt_pkg::ACT_TICK: c.kind = rrtt_pkg::K_TICK;
			default:            c.kind = rrtt_pkg::K_NONE;
		endcase
	end

	assign cmd.valid = req.valid;
	assign cmd.data  = c;
	assign req.ready = cmd.ready;

endmodule

@@ src/rrtt_fifo.sv @@
// short command queue between front and back
module rrtt_fifo (
	input  logic        clk,
	input  logic        arst_n,
	rrtt_chan_if.sink   wr,
	rrtt_chan_if.source rd
);

	localparam int D  = rrtt_pkg::QDEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(D - 1);

	rrtt_pkg::cmd_t mem_q [D];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign wr.ready = (cnt_q != CW'(D));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rp_q];
	assign push = wr.valid && wr.ready;
	assign pop  = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr.data;
		end
	end

endmodule

@@ src/rrtt_back.sv @@
// back end: slot table, one-slot-per-cycle scan (unless the result side stalls it) and result staging
module rrtt_back #(
	parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrtt_chan_if.sink   cmd,
	rrtt_chan_if.source res
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [3:0] CNT_CAP = 4'(rrtt_pkg::MAX_RES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       st_q;
	logic [IW-1:0]    idx_q;
	logic [3:0]       cnt_q;
	logic             pend_v_q;
	rrtt_pkg::res_t   pend_q;
	rrtt_pkg::cmd_t   cmd_q;
	logic             out_v_q;
	rrtt_pkg::res_t   out_q;

	logic [SLOTS-1:0] busy_q;
	logic [15:0]      next_id_q;
	logic [15:0]      id_q    [SLOTS];
	logic [7:0]       rdone_q [SLOTS];
	logic [7:0]       rallow_q[SLOTS];
	logic [31:0]      tmo_q   [SLOTS];
	logic [31:0]      tsend_q [SLOTS];

	logic             free_found;
	logic [IW-1:0]    free_idx;
	logic             pop, is_tick, due, can_retry, hit, out_free, stall, scan_end;
	logic             scan_go, out_load, open_arm;
	logic [31:0]      elapsed;
	rrtt_pkg::res_t   scan_res, first_res, quiet_res, flush_res;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign cmd.ready = (st_q == ST_IDLE);
	assign pop       = cmd.valid && cmd.ready;
	assign open_arm  = pop && (cmd.data.kind == rrtt_pkg::K_OPEN) && free_found
		&& cmd.data.send_ok;

	// result of a command that needs no scan
	always_comb begin
		first_res = '0;
		case (cmd.data.kind)
			rrtt_pkg::K_OPEN: begin
				if (!free_found) begin
					first_res.event_res = rrtt_pkg::EV_NOSLOT;
				end else begin
					first_res.event_res  = cmd.data.send_ok ? rrtt_pkg::EV_OPENED
						: rrtt_pkg::EV_SENDFAIL;
					first_res.slot_index = 3'(free_idx);
					first_res.id_out     = next_id_q;
				end
			end
			rrtt_pkg::K_LONG: first_res.event_res = rrtt_pkg::EV_TOOLONG;
			default:          first_res.event_res = rrtt_pkg::EV_NONE;
		endcase
	end

	// current slot of the scan
	assign is_tick   = (cmd_q.kind == rrtt_pkg::K_TICK);
	assign elapsed   = cmd_q.now_time - tsend_q[idx_q];
	assign due       = busy_q[idx_q] && (elapsed >= tmo_q[idx_q]);
	assign can_retry = (rdone_q[idx_q] < rallow_q[idx_q]);
	assign hit       = is_tick ? due : (busy_q[idx_q] && (id_q[idx_q] == cmd_q.match_id));

	always_comb begin
		scan_res            = '0;
		scan_res.slot_index = 3'(idx_q);
		scan_res.id_out     = id_q[idx_q];
		if (!is_tick) begin
			scan_res.event_res = rrtt_pkg::EV_DONE;
		end else if (can_retry) begin
			scan_res.event_res = rrtt_pkg::EV_RETRY;
			scan_res.attempt   = rdone_q[idx_q] + 8'd1;
		end else begin
			scan_res.event_res = rrtt_pkg::EV_TIMEOUT;
		end
	end

	always_comb begin
		quiet_res = '0;
		if (cmd_q.kind == rrtt_pkg::K_RESP) begin
			quiet_res.event_res = rrtt_pkg::EV_UNMATCHED;
			quiet_res.id_out    = cmd_q.match_id;
		end
		flush_res      = pend_v_q ? pend_q : quiet_res;
		flush_res.last = 1'b1;
	end

	assign out_free = !out_v_q || res.ready;
	// a new hit must push the held result out first
	assign stall    = hit && pend_v_q && !out_free;
	assign scan_go  = (st_q == ST_SCAN) && !stall;
	assign scan_end = (idx_q == LAST_IDX) || (hit && (!is_tick || cnt_q == CNT_CAP));
	assign out_load = (scan_go && hit && pend_v_q) || ((st_q == ST_FLUSH) && out_free);

	assign res.valid = out_v_q;
	assign res.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q <= '0;
						cnt_q <= '0;
						if (cmd.data.kind == rrtt_pkg::K_RESP
							|| cmd.data.kind == rrtt_pkg::K_TICK) begin
							pend_v_q <= 1'b0;
							st_q     <= ST_SCAN;
						end else begin
							pend_v_q <= 1'b1;
							st_q     <= ST_FLUSH;
						end
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (hit) begin
							pend_v_q <= 1'b1;
							cnt_q    <= cnt_q + 4'd1;
						end
						if (scan_end) begin
							st_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// busy bits and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			next_id_q <= 16'd1;
		end else begin
			if (pop && cmd.data.kind == rrtt_pkg::K_OPEN && free_found) begin
				next_id_q <= next_id_q + 16'd1;
			end
			if (open_arm) begin
				busy_q[free_idx] <= 1'b1;
			end
			if (scan_go && hit && !(is_tick && can_retry)) begin
				busy_q[idx_q] <= 1'b0;
			end
		end
	end

	// slot payload and staging registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= cmd.data;
			pend_q <= first_res;
		end
		if (open_arm) begin
			id_q[free_idx]     <= next_id_q;
			rdone_q[free_idx]  <= 8'd0;
			rallow_q[free_idx] <= cmd.data.retry_limit;
			tmo_q[free_idx]    <= cmd.data.timeout;
			tsend_q[free_idx]  <= cmd.data.now_time;
		end
		if (scan_go && hit) begin
			pend_q <= scan_res;
			if (is_tick && can_retry) begin
				rdone_q[idx_q] <= rdone_q[idx_q] + 8'd1;
				tsend_q[idx_q] <= cmd_q.now_time;
			end
		end
		if (scan_go && hit && pend_v_q) begin
			out_q <= pend_q;
		end else if (st_q == ST_FLUSH && out_free) begin
			out_q <= flush_res;
		end
	end

endmodule

@@ src/request_retry_timeout_tracker.sv @@
// top level of the request retry timeout tracker
// Tracks up to SLOTS outstanding requests. Input beats are classified and
// queued (two entries) ahead of the slot table. An open, a too-long request
// or an unknown action goes from idle straight to flush in the back end; a
// response or a tick scans the table one slot per cycle unless the result
// side stalls it. A tick yields up to eight results, the last one flagged;
// each result waits in an output register while the next beat is queued.
// The default timeout register resets to 3000; the user must write it through
// cfg only while the block is idle; the block itself does not enforce it.
module request_retry_timeout_tracker #(
	parameter int SLOTS       = rrtt_pkg::SLOTS_DEF,
	parameter int MAX_PAYLOAD = rrtt_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrtt_chan_if.sink   req,
	rrtt_chan_if.source res,
	rrtt_chan_if.sink   cfg
);

	rrtt_chan_if #(.T(rrtt_pkg::cmd_t)) enq_ch ();
	rrtt_chan_if #(.T(rrtt_pkg::cmd_t)) deq_ch ();

	rrtt_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.cmd    (enq_ch)
	);

	rrtt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (enq_ch),
		.rd     (deq_ch)
	);

	rrtt_back #(.SLOTS(SLOTS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (deq_ch),
		.res    (res)
	);

endmodule

@@ tb/rrtt_tb_pkg.sv @@
// slot table predictor and result scoreboard for the request retry timeout tracker
package rrtt_tb_pkg;
	import rrtt_pkg::*;

	class open_request_table;
		logic [31:0] dflt_timeout;
		bit          busy [SLOTS_DEF];
		logic [15:0] ids [SLOTS_DEF];
		logic [7:0]  tries [SLOTS_DEF];
		logic [7:0]  tries_max [SLOTS_DEF];
		logic [31:0] tmo [SLOTS_DEF];
		logic [31:0] sent_at [SLOTS_DEF];
		logic [15:0] id_next;
		res_t        expected_events [$];
		int          mismatches;

		function new();
			dflt_timeout = RESET_TIMEOUT;
			foreach (busy[i]) begin
				busy[i] = 1'b0;
				ids[i] = '0;
				tries[i] = '0;
				tries_max[i] = '0;
				tmo[i] = '0;
				sent_at[i] = '0;
			end
			id_next = 16'd1;
			mismatches = 0;
		endfunction

		function void write_default_timeout(logic [31:0] value);
			dflt_timeout = value;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function int free_count();
			int n;
			n = 0;
			foreach (busy[i])
				if (!busy[i])
					n++;
			return n;
		endfunction

		// id of a random live transaction, or any id when the table is empty
		function logic [15:0] busy_id();
			int live [$];
			foreach (busy[i])
				if (busy[i])
					live.push_back(i);
			if (live.size() == 0)
				return 16'($urandom);
			return ids[live[$urandom_range(0, live.size() - 1)]];
		endfunction

		function void add_event(logic [3:0] ev, int slot, logic [15:0] id, logic [7:0] att);
			res_t e;
			e.event_res = ev;
			e.slot_index = 3'(slot);
			e.id_out = id;
			e.attempt = att;
			e.last = 1'b0;
			expected_events.push_back(e);
		endfunction

		function void note_request(req_t r);
			int          slot;
			int          n;
			logic [31:0] elapsed;
			res_t        tail;
			slot = -1;
			n = 0;
			case (r.action)
				ACT_OPEN: begin
					if (r.payload_length > MAX_PAYLOAD_DEF) begin
						add_event(EV_TOOLONG, 0, '0, '0);
					end else begin
						for (int i = 0; i < SLOTS_DEF; i++) begin
							if (!busy[i]) begin
								slot = i;
								break;
							end
						end
						if (slot < 0) begin
							add_event(EV_NOSLOT, 0, '0, '0);
						end else if (!r.send_ok) begin
							add_event(EV_SENDFAIL, slot, id_next, '0);
							id_next++;
						end else begin
							busy[slot] = 1'b1;
							ids[slot] = id_next;
							tries[slot] = '0;
							tries_max[slot] = r.retry_limit_in;
							tmo[slot] = (r.request_timeout != 0) ? r.request_timeout : dflt_timeout;
							sent_at[slot] = r.now_time;
							add_event(EV_OPENED, slot, id_next, '0);
							id_next++;
						end
					end
				end
				ACT_RESP: begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (busy[i] && ids[i] == r.match_id) begin
							slot = i;
							break;
						end
					end
					if (slot < 0) begin
						add_event(EV_UNMATCHED, 0, r.match_id, '0);
					end else begin
						busy[slot] = 1'b0;
						add_event(EV_DONE, slot, ids[slot], '0);
					end
				end
				ACT_TICK: begin
					for (int i = 0; i < SLOTS_DEF && n < MAX_RES; i++) begin
						if (busy[i]) begin
							// elapsed time wraps with the millisecond counter
							elapsed = r.now_time - sent_at[i];
							if (elapsed >= tmo[i]) begin
								if (tries[i] < tries_max[i]) begin
									tries[i]++;
									sent_at[i] = r.now_time;
									add_event(EV_RETRY, i, ids[i], tries[i]);
								end else begin
									busy[i] = 1'b0;
									add_event(EV_TIMEOUT, i, ids[i], '0);
								end
								n++;
							end
						end
					end
					if (n == 0)
						add_event(EV_NONE, 0, '0, '0);
				end
				default: begin
					add_event(EV_NONE, 0, '0, '0);
				end
			endcase
			tail = expected_events.pop_back();
			tail.last = 1'b1;
			expected_events.push_back(tail);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got,
				realtime t);
			if (got !== want) begin
				$display("%0.0f ns: %s expected %0h actual %0h", t, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_event(res_t got, realtime t);
			res_t want;
			if (expected_events.size() == 0) begin
				$display("%0.0f ns: result beat with nothing expected, actual %p", t, got);
				mismatches++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("event_res", 16'(want.event_res), 16'(got.event_res), t);
			compare_field("slot_index", 16'(want.slot_index), 16'(got.slot_index), t);
			compare_field("id_out", want.id_out, got.id_out, t);
			compare_field("attempt", 16'(want.attempt), 16'(got.attempt), t);
			compare_field("last", 16'(want.last), 16'(got.last), t);
		endfunction
	endclass

endpackage

@@ tb/tb_request_retry_timeout_tracker.sv @@
// testbench of the request retry timeout tracker: directed and random beats checked
module tb_request_retry_timeout_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import rrtt_pkg::*;
	import rrtt_tb_pkg::*;

	logic clk;
	logic arst_n;

	rrtt_chan_if #(.T(req_t))        req_if ();
	rrtt_chan_if #(.T(res_t))        res_if ();
	rrtt_chan_if #(.T(logic [31:0])) cfg_if ();

	request_retry_timeout_tracker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	open_request_table sb;
	int                idle_pct;
	int                stall_pct;
	int                hold_left;
	logic [31:0]       ms_now;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls plus the long hold-off when asked
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_event(res_if.data, $realtime);
	end

	task automatic send_req(input req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_default(input logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.write_default_timeout(value);
	endtask

	function automatic req_t mk(logic [1:0] act, logic [31:0] now, logic [15:0] mid,
			logic [31:0] tmo, logic [7:0] rlim, logic [15:0] plen, logic ok);
		req_t r;
		r.action = act;
		r.now_time = now;
		r.match_id = mid;
		r.request_timeout = tmo;
		r.retry_limit_in = rlim;
		r.payload_length = plen;
		r.send_ok = ok;
		return r;
	endfunction

	function automatic req_t random_item();
		req_t r;
		int   pick;
		int   x;
		pick = $urandom_range(0, 99);
		x = $urandom_range(0, 99);
		// unused fields carry noise
		r.match_id = 16'($urandom);
		r.request_timeout = $urandom;
		r.retry_limit_in = 8'($urandom);
		r.payload_length = 16'($urandom);
		r.send_ok = 1'($urandom);
		if ($urandom_range(0, 99) < 3)
			ms_now += $urandom;
		else
			ms_now += $urandom_range(0, 25);
		r.now_time = ms_now;
		if (pick < 38) begin
			r.action = ACT_OPEN;
			r.payload_length = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 256))
				: 16'($urandom_range(257, 65535));
			r.send_ok = ($urandom_range(0, 99) < 88);
			if (x < 25)
				r.request_timeout = '0;
			else if (x < 90)
				r.request_timeout = $urandom_range(1, 60);
			if ($urandom_range(0, 99) < 80)
				r.retry_limit_in = 8'($urandom_range(0, 3));
		end else if (pick < 58) begin
			r.action = ACT_RESP;
			if (x < 75)
				r.match_id = sb.busy_id();
		end else if (pick < 96) begin
			r.action = ACT_TICK;
		end else begin
			r.action = ACT_NONE;
		end
		return r;
	endfunction

	initial begin
		int          idle_tab [4];
		int          stall_tab [4];
		logic [31:0] dflt_tab [4];

		idle_tab = '{0, 48, 0, 37};
		stall_tab = '{0, 0, 48, 37};
		dflt_tab = '{32'hFFFF_FFFF, 32'd1, 32'($urandom_range(20, 200)), RESET_TIMEOUT};
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		ms_now = '0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: length limits, send failure, retries, matching, unknown action
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'd0, 8'd0, 16'd256, 1'b1));
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'd5, 8'd1, 16'd257, 1'b1));
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'd5, 8'd1, 16'hFFFF, 1'b1));
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'd5, 8'd1, 16'd0, 1'b0));
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'd5, 8'd2, 16'd1, 1'b1));
		send_req(mk(ACT_OPEN, 32'd0, 16'd0, 32'hFFFF_FFFF, 8'hFF, 16'd100, 1'b1));
		send_req(mk(ACT_TICK, 32'd4, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_TICK, 32'd5, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_TICK, 32'd10, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_TICK, 32'd15, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_RESP, 32'd16, 16'd1, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_RESP, 32'd16, 16'd999, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_RESP, 32'd16, 16'hFFFF, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1));
		// fill the table, then one open too many
		repeat (7)
			send_req(mk(ACT_OPEN, 32'd20, 16'd0, 32'd1, 8'd0, 16'd8, 1'b1));
		send_req(mk(ACT_OPEN, 32'd20, 16'd0, 32'd1, 8'd0, 16'd8, 1'b1));
		// every slot due at once
		send_req(mk(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		drain();
		// zero default timeout: due on every tick
		write_default(32'd0);
		send_req(mk(ACT_OPEN, 32'd40, 16'd0, 32'd0, 8'd1, 16'd4, 1'b1));
		send_req(mk(ACT_TICK, 32'd40, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		send_req(mk(ACT_TICK, 32'd40, 16'd0, 32'd0, 8'd0, 16'd0, 1'b0));
		drain();

		// random phases, time stamps start just below the 32-bit wrap
		ms_now = 32'hFFFF_F000;
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			write_default(dflt_tab[p]);
			for (int k = 0; k < 45; k++) begin
				if (p == 2 && k == 10)
					hold_left = 400;
				send_req(random_item());
			end
			drain();
		end

		repeat (3 * SLOTS_DEF + 8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ request_retry_timeout_tracker.f @@
src/rrtt_pkg.sv
src/rrtt_chan_if.sv
src/rrtt_front.sv
src/rrtt_fifo.sv
src/rrtt_back.sv
src/request_retry_timeout_tracker.sv
tb/rrtt_tb_pkg.sv
tb/tb_request_retry_timeout_tracker.sv
